/* sv/i2cm_pkg.sv */
// ============================================================================
// i2cm_pkg
// Shared types and codes of the I2C master bit sequencer: transfer payloads,
// command codes, SDA drive codes, register indexes and the sequencer state.
// ============================================================================
package i2cm_pkg;

   // Command codes carried in the request's cmd field
   typedef enum logic [3:0] {
      CMD_TICK   = 4'd0,
      CMD_INIT   = 4'd1,
      CMD_START  = 4'd2,
      CMD_STOP   = 4'd3,
      CMD_SEND   = 4'd4,
      CMD_WAIT   = 4'd5,
      CMD_READ   = 4'd6,
      CMD_PROBE  = 4'd7,
      CMD_DEINIT = 4'd8
   } cmd_type;

   // SDA drive codes
   localparam logic [1:0] SDA_LOW  = 2'd0;
   localparam logic [1:0] SDA_HIGH = 2'd1;
   localparam logic [1:0] SDA_REL  = 2'd2;

   // Register indexes on the csr port
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_TICKS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_POLL_LIMIT = 2'd1;

   // Register widths and reset values
   localparam int unsigned DELAY_W = 16;
   localparam int unsigned POLL_W  = 8;
   localparam int unsigned WAIT_W  = 18;
   localparam logic [DELAY_W-1:0] DELAY_TICKS_RST    = 16'd1;
   localparam logic [POLL_W-1:0]  ACK_POLL_LIMIT_RST = 8'd200;

   // Bits per byte on the bus
   localparam logic [3:0] BYTE_BITS = 4'd8;

   // Sequencer phase, one-hot
   typedef enum logic [20:0] {
      PH_IDLE     = 21'h000001,
      PH_START_A  = 21'h000002,
      PH_START_B  = 21'h000004,
      PH_STOP_A   = 21'h000008,
      PH_STOP_B   = 21'h000010,
      PH_PISTOP_A = 21'h000020,
      PH_PISTOP_B = 21'h000040,
      PH_PTSTOP_A = 21'h000080,
      PH_PTSTOP_B = 21'h000100,
      PH_SEND_BIT = 21'h000200,
      PH_SEND_HI  = 21'h000400,
      PH_SEND_LO  = 21'h000800,
      PH_WA_A     = 21'h001000,
      PH_WA_B     = 21'h002000,
      PH_WA_POLL  = 21'h004000,
      PH_WA_END   = 21'h008000,
      PH_RD_HI    = 21'h010000,
      PH_RD_LO    = 21'h020000,
      PH_ACK_A    = 21'h040000,
      PH_ACK_B    = 21'h080000,
      PH_ACK_C    = 21'h100000
   } phase_type;

   // Request payload
   typedef struct packed {
      logic [3:0] cmd;
      logic [7:0] data_byte;
      logic       ack_after_read;
      logic       sda_in;
   } req_type;

   // Response payload
   typedef struct packed {
      logic       scl_level;
      logic [1:0] sda_mode;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       no_ack;
      logic       rejected;
   } rsp_type;

   // Sequencer state
   typedef struct packed {
      phase_type         phase;
      logic [3:0]        active_command;
      logic [7:0]        shift_byte;
      logic [3:0]        bit_count;
      logic [WAIT_W-1:0] wait_count;
      logic [POLL_W-1:0] poll_count;
      logic              scl_drive;
      logic [1:0]        sda_drive;
      logic              ack_choice;
      logic [7:0]        received_byte;
      logic              timeout_flag;
   } seq_state_type;

   localparam seq_state_type SEQ_STATE_RST = '{
      phase:          PH_IDLE,
      active_command: 4'd0,
      shift_byte:     8'd0,
      bit_count:      4'd0,
      wait_count:     '0,
      poll_count:     '0,
      scl_drive:      1'b1,
      sda_drive:      SDA_REL,
      ack_choice:     1'b0,
      received_byte:  8'd0,
      timeout_flag:   1'b0
   };

endpackage

/* sv/i2cm_step.sv */
// ============================================================================
// i2cm_step
// Next-state logic of the sequencer: applies one request item to the current
// state and forms the response for that item.
// ============================================================================
module i2cm_step
   import i2cm_pkg::*;
(
   input  seq_state_type       st,
   input  req_type             item,
   input  logic [DELAY_W-1:0]  delay_ticks,
   input  logic [POLL_W-1:0]   ack_poll_limit,
   output seq_state_type       st_nx,
   output rsp_type             rsp
);

   // Pin sequence helpers
   function automatic seq_state_type f_begin_stop(seq_state_type s, phase_type first,
                                                  logic [WAIT_W-1:0] w4);
      s.scl_drive  = 1'b0;
      s.sda_drive  = SDA_LOW;
      s.phase      = first;
      s.wait_count = w4;
      return s;
   endfunction

   function automatic seq_state_type f_begin_start(seq_state_type s, logic [WAIT_W-1:0] w4);
      s.sda_drive  = SDA_HIGH;
      s.scl_drive  = 1'b1;
      s.phase      = PH_START_A;
      s.wait_count = w4;
      return s;
   endfunction

   function automatic seq_state_type f_send_bit(seq_state_type s, logic [WAIT_W-1:0] w2);
      s.sda_drive  = s.shift_byte[7] ? SDA_HIGH : SDA_LOW;
      s.shift_byte = {s.shift_byte[6:0], 1'b0};
      s.phase      = PH_SEND_BIT;
      s.wait_count = w2;
      return s;
   endfunction

   function automatic seq_state_type f_begin_send(seq_state_type s, logic [7:0] byte_val,
                                                  logic [WAIT_W-1:0] w2);
      s.scl_drive  = 1'b0;
      s.shift_byte = byte_val;
      s.bit_count  = 4'd0;
      return f_send_bit(s, w2);
   endfunction

   function automatic seq_state_type f_begin_waitack(seq_state_type s, logic [WAIT_W-1:0] w1);
      s.sda_drive  = SDA_REL;
      s.phase      = PH_WA_A;
      s.wait_count = w1;
      return s;
   endfunction

   function automatic seq_state_type f_read_high(seq_state_type s, logic [WAIT_W-1:0] w1);
      s.scl_drive  = 1'b1;
      s.phase      = PH_RD_HI;
      s.wait_count = w1;
      return s;
   endfunction

   logic [DELAY_W-1:0] d_eff;
   logic [WAIT_W-1:0]  w1;
   logic [WAIT_W-1:0]  w2;
   logic [WAIT_W-1:0]  w4;
   logic               probe;
   logic               done;
   logic               rej;
   logic [3:0]         bc_inc;
   logic [WAIT_W-1:0]  wc_dec;
   seq_state_type      nx;

   // Delay lengths for one, two and four units
   assign d_eff = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
   assign w1    = WAIT_W'(d_eff);
   assign w2    = WAIT_W'({d_eff, 1'b0});
   assign w4    = WAIT_W'({d_eff, 2'b00});

   assign probe  = (st.active_command == CMD_PROBE);
   assign bc_inc = st.bit_count + 4'd1;
   assign wc_dec = (st.wait_count != '0) ? st.wait_count - WAIT_W'(1) : st.wait_count;

   // Sequencer step
   always_comb begin
      nx   = st;
      done = 1'b0;
      rej  = 1'b0;
      if (st.phase != PH_IDLE) begin
         if (item.cmd != CMD_TICK) begin
            rej = 1'b1;
         end else if (st.phase == PH_WA_POLL) begin
            // acknowledge polling, one sample per tick
            if (!item.sda_in) begin
               nx.scl_drive  = 1'b0;
               nx.phase      = PH_WA_END;
               nx.wait_count = w1;
            end else if (st.poll_count >= ack_poll_limit) begin
               nx.timeout_flag = 1'b1;
               nx = f_begin_stop(nx, probe ? PH_PTSTOP_A : PH_STOP_A, w4);
            end else begin
               nx.poll_count = st.poll_count + POLL_W'(1);
            end
         end else begin
            nx.wait_count = wc_dec;
            if (wc_dec == '0) begin
               // delay expired: next pin action
               case (st.phase)
                  PH_START_A: begin
                     nx.sda_drive  = SDA_LOW;
                     nx.phase      = PH_START_B;
                     nx.wait_count = w4;
                  end
                  PH_START_B: begin
                     nx.scl_drive = 1'b0;
                     if (probe) begin
                        nx = f_begin_send(nx, nx.shift_byte, w2);
                     end else begin
                        nx.phase = PH_IDLE;
                        done     = 1'b1;
                     end
                  end
                  PH_STOP_A: begin
                     nx.scl_drive  = 1'b1;
                     nx.phase      = PH_STOP_B;
                     nx.wait_count = w4;
                  end
                  PH_PISTOP_A: begin
                     nx.scl_drive  = 1'b1;
                     nx.phase      = PH_PISTOP_B;
                     nx.wait_count = w4;
                  end
                  PH_PTSTOP_A: begin
                     nx.scl_drive  = 1'b1;
                     nx.phase      = PH_PTSTOP_B;
                     nx.wait_count = w4;
                  end
                  PH_STOP_B: begin
                     nx.sda_drive = SDA_HIGH;
                     nx.phase     = PH_IDLE;
                     done         = 1'b1;
                  end
                  PH_PISTOP_B: begin
                     nx.sda_drive = SDA_HIGH;
                     nx = f_begin_start(nx, w4);
                  end
                  PH_PTSTOP_B: begin
                     nx.sda_drive = SDA_HIGH;
                     nx = f_begin_stop(nx, PH_STOP_A, w4);
                  end
                  PH_SEND_BIT: begin
                     nx.scl_drive  = 1'b1;
                     nx.phase      = PH_SEND_HI;
                     nx.wait_count = w2;
                  end
                  PH_SEND_HI: begin
                     nx.scl_drive  = 1'b0;
                     nx.phase      = PH_SEND_LO;
                     nx.wait_count = w2;
                  end
                  PH_SEND_LO: begin
                     nx.bit_count = bc_inc;
                     if (bc_inc < BYTE_BITS) begin
                        nx = f_send_bit(nx, w2);
                     end else if (probe) begin
                        nx = f_begin_waitack(nx, w1);
                     end else begin
                        nx.phase = PH_IDLE;
                        done     = 1'b1;
                     end
                  end
                  PH_WA_A: begin
                     nx.scl_drive  = 1'b1;
                     nx.phase      = PH_WA_B;
                     nx.wait_count = w1;
                  end
                  PH_WA_B: begin
                     nx.poll_count = '0;
                     nx.phase      = PH_WA_POLL;
                  end
                  PH_WA_END: begin
                     if (probe) begin
                        nx = f_begin_stop(nx, PH_STOP_A, w4);
                     end else begin
                        nx.phase = PH_IDLE;
                        done     = 1'b1;
                     end
                  end
                  PH_RD_HI: begin
                     nx.shift_byte = {st.shift_byte[6:0], item.sda_in};
                     nx.scl_drive  = 1'b0;
                     nx.phase      = PH_RD_LO;
                     nx.wait_count = w2;
                  end
                  PH_RD_LO: begin
                     nx.bit_count = bc_inc;
                     if (bc_inc < BYTE_BITS) begin
                        nx = f_read_high(nx, w1);
                     end else begin
                        nx.received_byte = st.shift_byte;
                        nx.scl_drive     = 1'b0;
                        nx.phase         = PH_ACK_A;
                        nx.wait_count    = w1;
                     end
                  end
                  PH_ACK_A: begin
                     nx.sda_drive  = st.ack_choice ? SDA_LOW : SDA_HIGH;
                     nx.phase      = PH_ACK_B;
                     nx.wait_count = w2;
                  end
                  PH_ACK_B: begin
                     nx.scl_drive  = 1'b1;
                     nx.phase      = PH_ACK_C;
                     nx.wait_count = w2;
                  end
                  PH_ACK_C: begin
                     nx.scl_drive = 1'b0;
                     nx.phase     = PH_IDLE;
                     done         = 1'b1;
                  end
                  default: begin
                     nx.phase = PH_IDLE;
                     done     = 1'b1;
                  end
               endcase
            end
         end
      end else if (item.cmd inside {[CMD_INIT:CMD_DEINIT]}) begin
         // new command while idle
         nx.active_command = item.cmd;
         case (item.cmd)
            CMD_INIT, CMD_STOP: begin
               nx = f_begin_stop(nx, PH_STOP_A, w4);
            end
            CMD_START: begin
               nx = f_begin_start(nx, w4);
            end
            CMD_SEND: begin
               nx = f_begin_send(nx, item.data_byte, w2);
            end
            CMD_WAIT: begin
               nx.timeout_flag = 1'b0;
               nx = f_begin_waitack(nx, w1);
            end
            CMD_READ: begin
               nx.ack_choice = item.ack_after_read;
               nx.sda_drive  = SDA_REL;
               nx.shift_byte = 8'd0;
               nx.bit_count  = 4'd0;
               nx = f_read_high(nx, w1);
            end
            CMD_PROBE: begin
               nx.timeout_flag = 1'b0;
               nx.shift_byte   = item.data_byte;
               nx = f_begin_stop(nx, PH_PISTOP_A, w4);
            end
            default: begin
               // deinit: both lines low, completes at once
               nx.scl_drive = 1'b0;
               nx.sda_drive = SDA_LOW;
               nx.phase     = PH_IDLE;
               done         = 1'b1;
            end
         endcase
      end
   end

   assign st_nx = nx;

   // Response fields
   assign rsp.scl_level = nx.scl_drive;
   assign rsp.sda_mode  = nx.sda_drive;
   assign rsp.busy_res  = (nx.phase != PH_IDLE);
   assign rsp.done_res  = done;
   assign rsp.rx_byte   = nx.received_byte;
   assign rsp.no_ack    = nx.timeout_flag;
   assign rsp.rejected  = rej;

endmodule

/* sv/i2c_master_bit_sequencer.sv */
// ============================================================================
// i2c_master_bit_sequencer
// I2C master pin sequencer: commands and ticks in, SCL/SDA drive and status
// out, one response per request.
// ============================================================================
// Usage:
//   req_* carries one item per transfer: a command while idle, then tick
//   items (cmd 0) that walk the timed SCL/SDA sequence. Each delay unit is
//   delay_ticks ticks, zero counting as one. Every request gives exactly one response on rsp_*
//   with the pin drive after that item and the busy/done/no-ack/rejected
//   flags. A command sent while busy is answered with rejected set.
//   csr_* writes delay_ticks (index 0) and ack_poll_limit (index 1); it is
//   always ready and is meant to be written while the block is idle.
// Pipeline and throughput:
//   An accepted request is held in the input register; the step logic
//   processes it and its response is registered in the output register
//   and presented from then on.
//   One item per cycle is sustained while rsp_stall is low: the input and
//   output registers each hold one transfer and the step logic is one pass.
// Reset: synchronous, active high. Clears both stages, puts the sequencer in
//   idle with SCL high and SDA released, and loads the register defaults.
// Stall: while rsp_stall holds the response, the input register keeps its
//   item and req_stall rises once that register is occupied.
module i2c_master_bit_sequencer
   import i2cm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DELAY_W-1:0]   csr_wdata
);

   logic               in_valid_ff, in_valid_in;
   req_type            in_item_ff;
   seq_state_type      st_ff, st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;
   logic [DELAY_W-1:0] delay_ticks_ff;
   logic [POLL_W-1:0]  ack_poll_limit_ff;
   rsp_type            step_rsp;
   logic               req_take;
   logic               advance;

   // Handshake
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // Step logic
   i2cm_step u_step (
      .st             (st_ff),
      .item           (in_item_ff),
      .delay_ticks    (delay_ticks_ff),
      .ack_poll_limit (ack_poll_limit_ff),
      .st_nx          (st_in),
      .rsp            (step_rsp)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= SEQ_STATE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff    <= DELAY_TICKS_RST;
         ack_poll_limit_ff <= ACK_POLL_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELAY_TICKS:    delay_ticks_ff    <= csr_wdata;
            CSR_ACK_POLL_LIMIT: ack_poll_limit_ff <= csr_wdata[POLL_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done response still reports busy");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |-> rsp_data.busy_res && !rsp_data.done_res)
      else $error("rejected response while sequencer idle or done");

   a_reject_keeps_state: assert property (@(posedge clock) disable iff (reset)
      advance && step_rsp.rejected |=> st_ff == $past(st_ff))
      else $error("rejected command changed sequencer state");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && rsp_data_ff == $past(step_rsp))
      else $error("processed item lost on the way to the response register");

endmodule

/* tb/sv/i2c_master_bit_sequencer_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// i2c_master_bit_sequencer_tb
// Self-checking bench for the I2C master bit sequencer. An item-level model of
// the pin sequencer predicts one response per accepted request, and a checker
// compares every response with the oldest prediction. Directed commands come
// first, then randomized command sequences under several timing settings,
// output back-pressure, and the delay and poll-limit extremes.
// ============================================================================
module i2c_master_bit_sequencer_tb;
   import i2cm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned HOLD_CYCLES = 60;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DELAY_W-1:0]   csr_wdata = '0;

   i2c_master_bit_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predicted pin sequencer: register copies and state after reset
   logic [DELAY_W-1:0] cfg_delay      = DELAY_TICKS_RST;
   logic [POLL_W-1:0]  cfg_poll_limit = ACK_POLL_LIMIT_RST;
   phase_type          ph             = PH_IDLE;
   logic [3:0]         act_cmd        = 4'd0;
   logic [7:0]         sh_byte        = 8'd0;
   logic [3:0]         bit_cnt        = 4'd0;
   logic [WAIT_W-1:0]  wait_cnt       = '0;
   logic [POLL_W-1:0]  poll_cnt       = '0;
   logic               scl_q          = 1'b1;
   logic [1:0]         sda_q          = SDA_REL;
   logic               ack_q          = 1'b0;
   logic [7:0]         rx_q           = 8'd0;
   logic               nack_q         = 1'b0;
   logic               done_q         = 1'b0;

   rsp_type     pin_forecast[$];
   rsp_type     want_rsp;
   int unsigned mismatches  = 0;
   int unsigned work_items  = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_orders = 0;
   int unsigned hold_served = 0;
   int unsigned hold_cnt    = 0;

   // Delay of a number of units, zero ticks per unit counts as one
   function void arm_delay(input int unsigned units);
      logic [31:0] per_unit;
      logic [31:0] total;
      per_unit = (cfg_delay == '0) ? 32'd1 : {16'd0, cfg_delay};
      total = units * per_unit;
      wait_cnt = total[WAIT_W-1:0];
   endfunction

   function void complete();
      ph = PH_IDLE;
      done_q = 1'b1;
   endfunction

   function void go_stop(input phase_type first);
      scl_q = 1'b0;
      sda_q = SDA_LOW;
      ph = first;
      arm_delay(4);
   endfunction

   function void go_start();
      sda_q = SDA_HIGH;
      scl_q = 1'b1;
      ph = PH_START_A;
      arm_delay(4);
   endfunction

   function void shift_out_bit();
      sda_q = sh_byte[7] ? SDA_HIGH : SDA_LOW;
      sh_byte = {sh_byte[6:0], 1'b0};
      ph = PH_SEND_BIT;
      arm_delay(2);
   endfunction

   function void go_send(input logic [7:0] value);
      scl_q = 1'b0;
      sh_byte = value;
      bit_cnt = 4'd0;
      shift_out_bit();
   endfunction

   function void go_waitack();
      sda_q = SDA_REL;
      ph = PH_WA_A;
      arm_delay(1);
   endfunction

   function void go_read_high();
      scl_q = 1'b1;
      ph = PH_RD_HI;
      arm_delay(1);
   endfunction

   // One SDA poll while waiting for the acknowledge
   function void sample_ack(input logic sda);
      if (sda == 1'b0) begin
         scl_q = 1'b0;
         ph = PH_WA_END;
         arm_delay(1);
      end else if (poll_cnt >= cfg_poll_limit) begin
         nack_q = 1'b1;
         go_stop((act_cmd == CMD_PROBE) ? PH_PTSTOP_A : PH_STOP_A);
      end else begin
         poll_cnt = poll_cnt + POLL_W'(1);
      end
   endfunction

   // Step taken when the running delay runs out
   function void timer_expired(input logic sda);
      logic probe;
      probe = (act_cmd == CMD_PROBE);
      case (ph)
         PH_START_A: begin
            sda_q = SDA_LOW;
            ph = PH_START_B;
            arm_delay(4);
         end
         PH_START_B: begin
            scl_q = 1'b0;
            if (probe) go_send(sh_byte);
            else complete();
         end
         PH_STOP_A: begin
            scl_q = 1'b1;
            ph = PH_STOP_B;
            arm_delay(4);
         end
         PH_PISTOP_A: begin
            scl_q = 1'b1;
            ph = PH_PISTOP_B;
            arm_delay(4);
         end
         PH_PTSTOP_A: begin
            scl_q = 1'b1;
            ph = PH_PTSTOP_B;
            arm_delay(4);
         end
         PH_STOP_B: begin
            sda_q = SDA_HIGH;
            complete();
         end
         PH_PISTOP_B: begin
            sda_q = SDA_HIGH;
            go_start();
         end
         PH_PTSTOP_B: begin
            // probe timeout: the timeout stop is followed by the probe's own stop
            sda_q = SDA_HIGH;
            go_stop(PH_STOP_A);
         end
         PH_SEND_BIT: begin
            scl_q = 1'b1;
            ph = PH_SEND_HI;
            arm_delay(2);
         end
         PH_SEND_HI: begin
            scl_q = 1'b0;
            ph = PH_SEND_LO;
            arm_delay(2);
         end
         PH_SEND_LO: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BYTE_BITS) shift_out_bit();
            else if (probe) go_waitack();
            else complete();
         end
         PH_WA_A: begin
            scl_q = 1'b1;
            ph = PH_WA_B;
            arm_delay(1);
         end
         PH_WA_B: begin
            poll_cnt = '0;
            ph = PH_WA_POLL;
         end
         PH_WA_END: begin
            if (probe) go_stop(PH_STOP_A);
            else complete();
         end
         PH_RD_HI: begin
            sh_byte = {sh_byte[6:0], sda};
            scl_q = 1'b0;
            ph = PH_RD_LO;
            arm_delay(2);
         end
         PH_RD_LO: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BYTE_BITS) begin
               go_read_high();
            end else begin
               rx_q = sh_byte;
               scl_q = 1'b0;
               ph = PH_ACK_A;
               arm_delay(1);
            end
         end
         PH_ACK_A: begin
            sda_q = ack_q ? SDA_LOW : SDA_HIGH;
            ph = PH_ACK_B;
            arm_delay(2);
         end
         PH_ACK_B: begin
            scl_q = 1'b1;
            ph = PH_ACK_C;
            arm_delay(2);
         end
         PH_ACK_C: begin
            scl_q = 1'b0;
            complete();
         end
         default: begin
            complete();
         end
      endcase
   endfunction

   // Pin drive and status expected after one request
   function rsp_type predict_pins(input req_type it);
      rsp_type r;
      logic    rej;
      rej = 1'b0;
      done_q = 1'b0;
      if (ph != PH_IDLE) begin
         if (it.cmd != CMD_TICK) begin
            rej = 1'b1;
         end else if (ph == PH_WA_POLL) begin
            sample_ack(it.sda_in);
         end else begin
            if (wait_cnt != '0) wait_cnt = wait_cnt - WAIT_W'(1);
            if (wait_cnt == '0) timer_expired(it.sda_in);
         end
      end else if (it.cmd >= CMD_INIT && it.cmd <= CMD_DEINIT) begin
         act_cmd = it.cmd;
         case (it.cmd)
            CMD_INIT, CMD_STOP: go_stop(PH_STOP_A);
            CMD_START: go_start();
            CMD_SEND: go_send(it.data_byte);
            CMD_WAIT: begin
               nack_q = 1'b0;
               go_waitack();
            end
            CMD_READ: begin
               ack_q = it.ack_after_read;
               sda_q = SDA_REL;
               sh_byte = 8'd0;
               bit_cnt = 4'd0;
               go_read_high();
            end
            CMD_PROBE: begin
               nack_q = 1'b0;
               sh_byte = it.data_byte;
               go_stop(PH_PISTOP_A);
            end
            default: begin
               scl_q = 1'b0;
               sda_q = SDA_LOW;
               complete();
            end
         endcase
      end
      r.scl_level = scl_q;
      r.sda_mode  = sda_q;
      r.busy_res  = (ph != PH_IDLE);
      r.done_res  = done_q;
      r.rx_byte   = rx_q;
      r.no_ack    = nack_q;
      r.rejected  = rej;
      return r;
   endfunction

   function void check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pin_forecast.size() == 0) begin
            $error("response transfer with no prediction pending");
            mismatches++;
         end else begin
            want_rsp = pin_forecast.pop_front();
            check_field("scl_level", 8'(want_rsp.scl_level), 8'(rsp_data.scl_level));
            check_field("sda_mode",  8'(want_rsp.sda_mode),  8'(rsp_data.sda_mode));
            check_field("busy_res",  8'(want_rsp.busy_res),  8'(rsp_data.busy_res));
            check_field("done_res",  8'(want_rsp.done_res),  8'(rsp_data.done_res));
            check_field("rx_byte",   want_rsp.rx_byte,       rsp_data.rx_byte);
            check_field("no_ack",    8'(want_rsp.no_ack),    8'(rsp_data.no_ack));
            check_field("rejected",  8'(want_rsp.rejected),  8'(rsp_data.rejected));
         end
      end
   end

   // Response stall: random, or a long hold-off when one is ordered
   always @(posedge clock) begin
      if (hold_orders != hold_served) begin
         hold_served = hold_orders;
         hold_cnt = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt = hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("i2c_master_bit_sequencer_tb: done, errors");
         $finish;
      end
   end

   // One request transfer; prediction happens at acceptance
   task send_item(input req_type it);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if ((ph != PH_IDLE && it.cmd == CMD_TICK) ||
          (ph == PH_IDLE && it.cmd >= CMD_INIT && it.cmd <= CMD_DEINIT))
         work_items++;
      pin_forecast.push_back(predict_pins(it));
   endtask

   function req_type make_item(input logic [3:0] c, input logic [7:0] d, input logic a,
                               input logic s);
      req_type it;
      it.cmd = c;
      it.data_byte = d;
      it.ack_after_read = a;
      it.sda_in = s;
      return it;
   endfunction

   // Tick with SDA low for ack with ack_low_pct while polling, else high with high_pct
   task send_tick(input int unsigned ack_low_pct, input int unsigned high_pct);
      logic s;
      if (ph == PH_WA_POLL) s = !($urandom_range(99) < ack_low_pct);
      else s = ($urandom_range(99) < high_pct);
      send_item(make_item(CMD_TICK, 8'($urandom), 1'($urandom), s));
   endtask

   // Tick the running sequence to its end, with stray commands mixed in
   task run_sequence(input int unsigned ack_low_pct, input int unsigned high_pct,
                     input int unsigned reject_pct);
      while (ph != PH_IDLE) begin
         if ($urandom_range(99) < reject_pct)
            send_item(make_item(4'($urandom_range(1, 15)), 8'($urandom), 1'($urandom),
                                1'($urandom)));
         else
            send_tick(ack_low_pct, high_pct);
      end
   endtask

   task run_command(input logic [3:0] c, input logic [7:0] d, input logic a,
                    input int unsigned ack_low_pct, input int unsigned high_pct,
                    input int unsigned reject_pct);
      send_item(make_item(c, d, a, 1'($urandom)));
      run_sequence(ack_low_pct, high_pct, reject_pct);
   endtask

   // Sender pauses until every predicted response has arrived
   task drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pin_forecast.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers; the sequencer must be idle and drained
   task set_timing(input logic [DELAY_W-1:0] ticks, input logic [POLL_W-1:0] limit);
      csr_valid <= 1'b1;
      csr_index <= CSR_DELAY_TICKS;
      csr_wdata <= ticks;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_delay = ticks;
      csr_index <= CSR_ACK_POLL_LIMIT;
      csr_wdata <= {{(DELAY_W-POLL_W){1'b0}}, limit};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_poll_limit = limit;
      csr_valid <= 1'b0;
   endtask

   task retime_random();
      drain_responses();
      set_timing(16'($urandom_range(1, 3)), 8'($urandom_range(1, 6)));
   endtask

   task set_idling(input int unsigned send_pct, input int unsigned stall_pct);
      send_gap_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Every command once, field extremes, ignored and rejected commands
   task test_directed_commands();
      send_item(make_item(CMD_TICK, 8'h00, 1'b0, 1'b0));
      send_item(make_item(4'hF, 8'hFF, 1'b1, 1'b1));
      send_item(make_item(4'h9, 8'h00, 1'b0, 1'b0));
      run_command(CMD_INIT, 8'h00, 1'b0, 100, 50, 0);
      run_command(CMD_START, 8'h00, 1'b0, 100, 50, 0);
      run_command(CMD_STOP, 8'h00, 1'b0, 100, 50, 0);
      run_command(CMD_SEND, 8'hFF, 1'b0, 100, 50, 0);
      run_command(CMD_SEND, 8'h00, 1'b1, 100, 50, 0);
      run_command(CMD_WAIT, 8'h00, 1'b0, 100, 50, 0);
      run_command(CMD_READ, 8'h00, 1'b1, 100, 100, 0);
      run_command(CMD_READ, 8'hFF, 1'b0, 100, 0, 0);
      run_command(CMD_PROBE, 8'hA0, 1'b0, 100, 50, 0);
      // commands while busy are rejected
      send_item(make_item(CMD_SEND, 8'h5A, 1'b0, 1'b0));
      send_tick(100, 50);
      send_item(make_item(CMD_DEINIT, 8'h00, 1'b0, 1'b0));
      send_item(make_item(4'hF, 8'hFF, 1'b1, 1'b1));
      run_sequence(100, 50, 20);
      send_item(make_item(CMD_DEINIT, 8'h00, 1'b0, 1'b0));
   endtask

   // Random command sequences, timing re-picked halfway through
   task test_random_traffic(input int unsigned quota);
      int unsigned stop_at;
      int unsigned half_at;
      logic        retimed;
      int unsigned ack_low;
      stop_at = work_items + quota;
      half_at = work_items + quota / 2;
      retimed = 1'b0;
      retime_random();
      while (work_items < stop_at) begin
         if (!retimed && work_items >= half_at) begin
            retime_random();
            retimed = 1'b1;
         end
         if ($urandom_range(99) < 8) begin
            // noise: idle tick or unknown command
            send_item(make_item(($urandom_range(1) != 0) ? 4'($urandom_range(9, 15)) : CMD_TICK,
                                8'($urandom), 1'($urandom), 1'($urandom)));
         end else begin
            ack_low = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 100);
            run_command(4'($urandom_range(1, 8)), 8'($urandom), 1'($urandom), ack_low, 50, 3);
         end
      end
   endtask

   // Long response hold-off, and a sender pause in the middle of a sequence
   task test_back_pressure();
      send_item(make_item(CMD_READ, 8'($urandom), 1'($urandom), 1'($urandom)));
      hold_orders++;
      run_sequence(100, 50, 0);
      send_item(make_item(CMD_PROBE, 8'($urandom), 1'b0, 1'b0));
      repeat (10) send_tick(50, 50);
      drain_responses();
      run_sequence(50, 50, 0);
   endtask

   // Long and zero delays, poll-limit extremes, ack timeouts, no-ack persistence
   task test_timing_extremes();
      drain_responses();
      set_timing(16'd20, 8'd1);
      run_command(CMD_WAIT, 8'($urandom), 1'($urandom), 100, 50, 0);
      drain_responses();
      set_timing(16'd1, 8'd255);
      run_command(CMD_WAIT, 8'($urandom), 1'($urandom), 0, 50, 0);
      drain_responses();
      // zero ticks per unit behaves as one
      set_timing(16'd0, 8'd1);
      run_command(CMD_WAIT, 8'($urandom), 1'($urandom), 0, 50, 0);
      run_command(CMD_READ, 8'($urandom), 1'($urandom), 100, 50, 0);
      run_command(CMD_PROBE, 8'($urandom), 1'($urandom), 0, 50, 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_idling(15, 52);
      test_directed_commands();
      test_random_traffic(100);

      set_idling(52, 15);
      test_back_pressure();
      test_random_traffic(100);

      set_idling(0, 0);
      test_random_traffic(100);
      test_timing_extremes();

      drain_responses();
      repeat (6) @(posedge clock);
      if (mismatches == 0 && pin_forecast.size() == 0)
         $display("i2c_master_bit_sequencer_tb: done, clean");
      else
         $display("i2c_master_bit_sequencer_tb: done, errors");
      $finish;
   end

endmodule
